@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cau_pkg.sv @@
// shared constants and types of the complex arithmetic unit
package cau_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } ctl_t;
endpackage

@@ hw/rtl/cau_front.sv @@
// operand register, products, combine and sign-magnitude conversion
module cau_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [1:0]                            command,
  input  logic signed [DATA_WIDTH-1:0]          first_real,
  input  logic signed [DATA_WIDTH-1:0]          first_imag,
  input  logic signed [DATA_WIDTH-1:0]          second_real,
  input  logic signed [DATA_WIDTH-1:0]          second_imag,
  output cau_pkg::ctl_t                         ctl,
  output logic [3*DATA_WIDTH+FRAC_BITS:0]       mag_re,
  output logic [3*DATA_WIDTH+FRAC_BITS:0]       mag_im,
  output logic [3*DATA_WIDTH+FRAC_BITS:0]       den
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int XW = 3 * W + FRAC_BITS + 1;

  // stage 1: operands
  logic                v1;
  logic [1:0]          cmd1;
  logic signed [W-1:0] a1, b1, c1, d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    cmd1 <= command;
    a1   <= first_real;
    b1   <= first_imag;
    c1   <= second_real;
    d1   <= second_imag;
  end

  // stage 2: products and plain sums or differences
  logic                 v2;
  logic [1:0]           cmd2;
  logic signed [PW-1:0] ac, bd, ad, bc, cc, dd;
  logic signed [W:0]    sre, sim;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    cmd2 <= cmd1;
    ac   <= a1 * c1;
    bd   <= b1 * d1;
    ad   <= a1 * d1;
    bc   <= b1 * c1;
    cc   <= c1 * c1;
    dd   <= d1 * d1;
    if (cmd1 == CMD_SUB) begin
      sre <= a1 - c1;
      sim <= b1 - d1;
    end else begin
      sre <= a1 + c1;
      sim <= b1 + d1;
    end
  end

  // stage 3: combine per command
  logic                 v3;
  logic [1:0]           cmd3;
  logic signed [PW+1:0] re3, im3;
  logic [PW:0]          den3;
  logic signed [PW+1:0] re3_next, im3_next;

  always_comb begin
    case (cmd2)
      CMD_MUL: begin
        re3_next = ac - bd;
        im3_next = ad + bc;
      end
      CMD_DIV: begin
        re3_next = ac + bd;
        im3_next = bc - ad;
      end
      default: begin
        re3_next = (PW+2)'(sre);
        im3_next = (PW+2)'(sim);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    cmd3 <= cmd2;
    re3  <= re3_next;
    im3  <= im3_next;
    den3 <= {1'b0, PW'(cc)} + {1'b0, PW'(dd)};
  end

  // stage 4: magnitude, rescale or numerator shift, overflow screen
  logic [PW+1:0] abs_re, abs_im;
  logic [XW-1:0] num_re, num_im, den_w, den_lim;
  logic [XW-1:0] mag_re_next, mag_im_next;
  ctl_t          ctl_next;

  always_comb begin
    abs_re  = re3[PW+1] ? (~re3 + 1'b1) : re3;
    abs_im  = im3[PW+1] ? (~im3 + 1'b1) : im3;
    num_re  = XW'(abs_re) << FRAC_BITS;
    num_im  = XW'(abs_im) << FRAC_BITS;
    den_w   = XW'(den3);
    den_lim = den_w << W;
    ctl_next.valid  = v3;
    ctl_next.is_div = (cmd3 == CMD_DIV);
    ctl_next.dz     = (cmd3 == CMD_DIV) && (den3 == '0);
    ctl_next.neg_re = re3[PW+1];
    ctl_next.neg_im = im3[PW+1];
    ctl_next.ovf_re = (cmd3 == CMD_DIV) && (num_re >= den_lim);
    ctl_next.ovf_im = (cmd3 == CMD_DIV) && (num_im >= den_lim);
    case (cmd3)
      CMD_MUL: begin
        mag_re_next = XW'(abs_re >> FRAC_BITS);
        mag_im_next = XW'(abs_im >> FRAC_BITS);
      end
      CMD_DIV: begin
        mag_re_next = num_re;
        mag_im_next = num_im;
      end
      default: begin
        mag_re_next = XW'(abs_re);
        mag_im_next = XW'(abs_im);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
    mag_re <= mag_re_next;
    mag_im <= mag_im_next;
    den    <= den_w;
  end
endmodule

@@ hw/rtl/cau_div_stage.sv @@
// one restoring division step for both parts, quotient bit K
module cau_div_stage #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int K          = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cau_pkg::ctl_t                   ctl_in,
  input  logic [3*DATA_WIDTH+FRAC_BITS:0] rem_re_in,
  input  logic [3*DATA_WIDTH+FRAC_BITS:0] rem_im_in,
  input  logic [3*DATA_WIDTH+FRAC_BITS:0] den_in,
  input  logic [DATA_WIDTH-1:0]           q_re_in,
  input  logic [DATA_WIDTH-1:0]           q_im_in,
  output cau_pkg::ctl_t                   ctl_out,
  output logic [3*DATA_WIDTH+FRAC_BITS:0] rem_re_out,
  output logic [3*DATA_WIDTH+FRAC_BITS:0] rem_im_out,
  output logic [3*DATA_WIDTH+FRAC_BITS:0] den_out,
  output logic [DATA_WIDTH-1:0]           q_re_out,
  output logic [DATA_WIDTH-1:0]           q_im_out
);
  import cau_pkg::*;

  localparam int XW = 3 * DATA_WIDTH + FRAC_BITS + 1;

  logic [XW-1:0]         sh;
  logic                  take_re, take_im;
  logic [DATA_WIDTH-1:0] q_re_next, q_im_next;

  always_comb begin
    sh      = den_in << K;
    take_re = ctl_in.is_div && !ctl_in.dz && !ctl_in.ovf_re && (rem_re_in >= sh);
    take_im = ctl_in.is_div && !ctl_in.dz && !ctl_in.ovf_im && (rem_im_in >= sh);
    q_re_next    = q_re_in;
    q_im_next    = q_im_in;
    q_re_next[K] = take_re;
    q_im_next[K] = take_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    rem_re_out <= take_re ? (rem_re_in - sh) : rem_re_in;
    rem_im_out <= take_im ? (rem_im_in - sh) : rem_im_in;
    den_out    <= den_in;
    q_re_out   <= q_re_next;
    q_im_out   <= q_im_next;
  end
endmodule

@@ hw/rtl/cau_back.sv @@
// sign restore, saturation and status register
module cau_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cau_pkg::ctl_t                   ctl,
  input  logic [3*DATA_WIDTH+FRAC_BITS:0] rem_re,
  input  logic [3*DATA_WIDTH+FRAC_BITS:0] rem_im,
  input  logic [DATA_WIDTH-1:0]           q_re,
  input  logic [DATA_WIDTH-1:0]           q_im,
  output logic                            done,
  output logic signed [DATA_WIDTH-1:0]    result_real,
  output logic signed [DATA_WIDTH-1:0]    result_imag,
  output logic [1:0]                      status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int XW = 3 * W + FRAC_BITS + 1;

  // returns {over, value}
  function automatic logic [W:0] sat_part(input logic neg, input logic ovf,
                                          input logic [XW-1:0] m);
    logic [XW-1:0] lim;
    logic          over;
    logic [W-1:0]  val;
    lim  = neg ? (XW'(1) << (W-1)) : ((XW'(1) << (W-1)) - XW'(1));
    over = ovf || (m > lim);
    if (over) begin
      val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      val = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    end
    return {over, val};
  endfunction

  logic [XW-1:0] m_re, m_im;
  logic [W:0]    s_re, s_im;

  always_comb begin
    m_re = ctl.is_div ? XW'(q_re) : rem_re;
    m_im = ctl.is_div ? XW'(q_im) : rem_im;
    s_re = sat_part(ctl.neg_re, ctl.ovf_re, m_re);
    s_im = sat_part(ctl.neg_im, ctl.ovf_im, m_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      result_real <= '0;
      result_imag <= '0;
      status      <= ST_OK;
    end else begin
      done <= ctl.valid;
      if (!ctl.valid || ctl.dz) begin
        result_real <= '0;
        result_imag <= '0;
      end else begin
        result_real <= s_re[W-1:0];
        result_imag <= s_im[W-1:0];
      end
      if (!ctl.valid) begin
        status <= ST_OK;
      end else if (ctl.dz) begin
        status <= ST_DZ;
      end else if (s_re[W] || s_im[W]) begin
        status <= ST_SAT;
      end else begin
        status <= ST_OK;
      end
    end
  end
endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
// top level of the complex arithmetic unit
// complex add, subtract, multiply and divide on signed fixed point operands
// (FRAC_BITS fraction bits in DATA_WIDTH). an item is taken whenever start is
// high; busy is always low, so one item may enter every cycle. each result
// shows on result_real, result_imag and status for one cycle with done high,
// after its item was taken and has passed four front stages, one divider
// stage per quotient bit and one output stage. every command walks the whole
// divider pipeline so results come back in order. multiply and divide
// truncate toward zero; a part out of range clamps and sets status 1;
// divide by zero returns zeros with status 2.
// results cannot be held off, so a receiver must take them as they come.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic signed [DATA_WIDTH-1:0] first_real,
  input  logic signed [DATA_WIDTH-1:0] first_imag,
  input  logic signed [DATA_WIDTH-1:0] second_real,
  input  logic signed [DATA_WIDTH-1:0] second_imag,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result_real,
  output logic signed [DATA_WIDTH-1:0] result_imag,
  output logic [1:0]                   status
);
  import cau_pkg::*;
`include "assert_macros.svh"

  localparam int W   = DATA_WIDTH;
  localparam int XW  = 3 * W + FRAC_BITS + 1;
  localparam int LAT = W + 5;

  // the pipeline never stalls
  assign busy = 1'b0;

  // chain of divider stages, index 0 is the front output
  ctl_t          ctl_c    [W+1];
  logic [XW-1:0] rem_re_c [W+1];
  logic [XW-1:0] rem_im_c [W+1];
  logic [XW-1:0] den_c    [W+1];
  logic [W-1:0]  q_re_c   [W+1];
  logic [W-1:0]  q_im_c   [W+1];

  assign q_re_c[0] = '0;
  assign q_im_c[0] = '0;

  cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .command     (command),
    .first_real  (first_real),
    .first_imag  (first_imag),
    .second_real (second_real),
    .second_imag (second_imag),
    .ctl         (ctl_c[0]),
    .mag_re      (rem_re_c[0]),
    .mag_im      (rem_im_c[0]),
    .den         (den_c[0])
  );

  // most significant quotient bit first
  for (genvar i = 0; i < W; i++) begin : g_div
    cau_div_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .K          (W - 1 - i)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .ctl_in     (ctl_c[i]),
      .rem_re_in  (rem_re_c[i]),
      .rem_im_in  (rem_im_c[i]),
      .den_in     (den_c[i]),
      .q_re_in    (q_re_c[i]),
      .q_im_in    (q_im_c[i]),
      .ctl_out    (ctl_c[i+1]),
      .rem_re_out (rem_re_c[i+1]),
      .rem_im_out (rem_im_c[i+1]),
      .den_out    (den_c[i+1]),
      .q_re_out   (q_re_c[i+1]),
      .q_im_out   (q_im_c[i+1])
    );
  end

  cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl_c[W]),
    .rem_re      (rem_re_c[W]),
    .rem_im      (rem_im_c[W]),
    .q_re        (q_re_c[W]),
    .q_im        (q_im_c[W]),
    .done        (done),
    .result_real (result_real),
    .result_imag (result_imag),
    .status      (status)
  );

  // fixed latency from start to done
  `CAU_ASSERT_IMP(a_latency, done, $past(start, LAT), "done without a matching start")
  // divide by zero returns zeros
  `CAU_ASSERT_IMP(a_dz_zero, done && status == ST_DZ,
                  result_real == '0 && result_imag == '0, "nonzero result on divide by zero")
  // outputs quiet between results
  `CAU_ASSERT_IMP(a_quiet, !done,
                  status == ST_OK && result_real == '0 && result_imag == '0,
                  "result ports active without done")
endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench of the complex arithmetic unit
module tb;
  import cau_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1150;
  localparam int LATENCY = DW + 5;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [1:0]           st;
  } cplx_result_t;

  // checks each result against the oldest predicted one
  class result_board;
    cplx_result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // saturate a wide signed value to DW bits, flagging a clamp
    static function logic signed [DW-1:0] clamp(logic signed [191:0] v, bit force_ovf,
                                                 ref bit sat);
      logic signed [191:0] hi_lim;
      logic signed [191:0] lo_lim;
      hi_lim = (192'sd1 <<< (DW - 1)) - 1;
      lo_lim = -(192'sd1 <<< (DW - 1));
      if (force_ovf || v > hi_lim) begin
        sat = 1;
        return hi_lim[DW-1:0];
      end
      if (v < lo_lim) begin
        sat = 1;
        return lo_lim[DW-1:0];
      end
      return v[DW-1:0];
    endfunction

    // truncating divide of (num << FB) by den, toward zero
    static function logic signed [191:0] div_trunc(logic signed [191:0] num,
                                                   logic signed [191:0] den);
      logic [191:0] mag;
      logic [191:0] q;
      mag = num < 0 ? -num : num;
      q = (mag << FB) / den;
      return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    // right shift on the magnitude, so truncation is toward zero
    static function logic signed [191:0] rescale(logic signed [191:0] v);
      logic [191:0] mag;
      mag = v < 0 ? -v : v;
      mag = mag >> FB;
      return v < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    function void note_item(logic [1:0] cmd, logic signed [DW-1:0] a,
                            logic signed [DW-1:0] b, logic signed [DW-1:0] c,
                            logic signed [DW-1:0] d);
      logic signed [191:0] wa, wb, wc, wd, re, im, den;
      cplx_result_t r;
      bit sat;
      wa = a; wb = b; wc = c; wd = d;
      sat = 0;
      r.st = ST_OK;
      case (cmd)
        CMD_ADD: begin
          re = wa + wc; im = wb + wd;
        end
        CMD_SUB: begin
          re = wa - wc; im = wb - wd;
        end
        CMD_MUL: begin
          re = rescale(wa * wc - wb * wd);
          im = rescale(wa * wd + wb * wc);
        end
        default: begin
          den = wc * wc + wd * wd;
          if (den == 0) begin
            re = 0; im = 0;
          end else begin
            re = div_trunc(wa * wc + wb * wd, den);
            im = div_trunc(wb * wc - wa * wd, den);
          end
        end
      endcase
      r.re = clamp(re, 0, sat);
      r.im = clamp(im, 0, sat);
      if (sat) r.st = ST_SAT;
      if (cmd == CMD_DIV && den == 0) r.st = ST_DZ;
      pending.push_back(r);
    endfunction

    function void report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
      $display("  %s: got %h, want %h", what, got, want);
      errors++;
    endfunction

    function void check_result(logic signed [DW-1:0] re, logic signed [DW-1:0] im,
                               logic [1:0] st);
      cplx_result_t w;
      if (pending.size() == 0) begin
        report("result with nothing pending", re, '0);
        return;
      end
      w = pending.pop_front();
      if (re !== w.re) report("result_real", re, w.re);
      if (im !== w.im) report("result_imag", im, w.im);
      if (st !== w.st) report("status", st, w.st);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] command = CMD_ADD;
  logic signed [DW-1:0] first_real = 0, first_imag = 0, second_real = 0, second_imag = 0;
  logic busy, done;
  logic signed [DW-1:0] result_real, result_imag;
  logic [1:0] status;

  result_board board = new();
  int idle_cycles = 0;

  always #10 clk = ~clk;

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .first_real(first_real), .first_imag(first_imag),
    .second_real(second_real), .second_imag(second_imag),
    .done(done), .result_real(result_real), .result_imag(result_imag),
    .status(status)
  );

  // results are taken at the edge that ends their strobe cycle
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result_real, result_imag, status);
  end

  // watchdog: cycles with neither an item nor a result taken
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("complex_arithmetic_unit: mismatch");
        $finish;
      end
    end
  end

  // drop start for a random gap (possibly none), then present one item and hold it until taken
  task automatic send_item(logic [1:0] cmd, logic [DW-1:0] a, logic [DW-1:0] b,
                           logic [DW-1:0] c, logic [DW-1:0] d);
    int gap;
    gap = $urandom_range(0, 5);
    if (($urandom & 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    first_real <= a; first_imag <= b;
    second_real <= c; second_imag <= d;
    do @(posedge clk); while (busy);
    board.note_item(cmd, a, b, c, d);
  endtask

  // operand mix: extremes, small values and full-range noise
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom_range(0, 8) << FB;
      4: return -($urandom_range(1, 8) << FB);
      5: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [DW-1:0] mx, mn;
    logic [1:0] cmd;
    int wait_cycles;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes on each command, overflow on every path, divide by zero
    for (int k = 0; k < 4; k++) begin
      cmd = k[1:0];
      send_item(cmd, mx, mx, mx, mx);
      send_item(cmd, mn, mn, mn, mn);
      send_item(cmd, mx, mn, mn, mx);
      send_item(cmd, 32'h0001_8000, 32'hfffe_8000, 32'h0000_4000, 32'hffff_c000);
    end
    send_item(CMD_DIV, mx, mn, 0, 0);
    send_item(CMD_DIV, 0, 0, 0, 0);
    send_item(CMD_DIV, mx, mx, 1, 0);
    send_item(CMD_DIV, mn, 0, 0, 32'hffff_ffff);
    send_item(CMD_MUL, mn, 0, mn, 0);
    send_item(CMD_ADD, mx, 0, 1, 0);
    send_item(CMD_SUB, mn, 0, 1, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      cmd = 2'($urandom_range(0, 3));
      if (cmd == CMD_DIV && ($urandom % 16) == 0)
        send_item(cmd, pick_operand(), pick_operand(), 0, 0);
      else
        send_item(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    start <= 0;

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 50 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 5) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("complex_arithmetic_unit: match");
    end else begin
      $display("complex_arithmetic_unit: mismatch");
    end
    $finish;
  end
endmodule

@@ complex_arithmetic_unit.f @@
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_stage.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arithmetic_unit.sv
tb/sv/tb.sv
